[hw/rtl/bcd_stopwatch_with_debounce_macros.svh]
// Assertion macros shared by the stopwatch checker.
`ifndef BCD_STOPWATCH_WITH_DEBOUNCE_MACROS_SVH
`define BCD_STOPWATCH_WITH_DEBOUNCE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BCDSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stopwatch check failed");

// Next-cycle implication, disabled while reset is held.
`define BCDSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stopwatch check failed");

`endif

[hw/rtl/bcdsw_pkg.sv]
// Shared types and constants of the BCD stopwatch with debounce.
package bcdsw_pkg;

    localparam int CNT_W      = 16;
    localparam int LIMIT_W    = 16;
    localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int NUM_DIGITS = 6;
    localparam int DIGIT_W    = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(500);

    // Register index decoded from the word address.
    localparam logic REG_DEBOUNCE_LIMIT = 1'b0;

    // Digit positions along the chain.
    localparam int D_MS_ONES  = 0;
    localparam int D_MS_TENS  = 1;
    localparam int D_MS_HUNDS = 2;
    localparam int D_SEC_ONES = 3;
    localparam int D_SEC_TENS = 4;
    localparam int D_MINUTES  = 5;

    typedef enum logic [1:0] {
        CMD_PRESS    = 2'd0,
        CMD_MS_TICK  = 2'd1,
        CMD_SEC_TICK = 2'd2,
        CMD_SAMPLE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_STOP = 2'd2
    } t_mode;

    // Requests into the debounce unit.
    typedef struct packed {
        logic press;
        logic sample;
        logic level;
    } t_deb_ctrl;

    // Status out of the debounce unit.
    typedef struct packed {
        logic blocked;
        logic active;
    } t_deb_status;

    // Wrap modulus of each digit position.
    function automatic logic [DIGIT_W-1:0] digit_modulus(input int pos);
        logic [DIGIT_W-1:0] m;
        m = DIGIT_W'(10);
        if (pos == D_SEC_TENS) begin
            m = DIGIT_W'(6);
        end
        return m;
    endfunction

endpackage

[hw/rtl/bcdsw_digit_cell.sv]
// One BCD digit cell of the stopwatch counter chain.
module bcdsw_digit_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_inc,
    input  logic [bcdsw_pkg::DIGIT_W-1:0]  i_modulus,
    output logic [bcdsw_pkg::DIGIT_W-1:0]  o_digit,
    output logic                           o_carry
);
    import bcdsw_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic               at_top;

    assign at_top  = (r_digit == (i_modulus - DIGIT_W'(1)));
    assign o_carry = i_inc && at_top;
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_clear) begin
            n_digit = '0;
        end else if (i_inc) begin
            n_digit = at_top ? '0 : r_digit + DIGIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

endmodule

[hw/rtl/bcdsw_debounce.sv]
// Press blocking and debounce sample counters.
module bcdsw_debounce (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bcdsw_pkg::t_deb_ctrl           i_ctrl,
    input  logic [bcdsw_pkg::LIMIT_W-1:0]  i_limit,
    output bcdsw_pkg::t_deb_status         o_status
);
    import bcdsw_pkg::*;

    logic             r_blocked;
    logic             r_active;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_low;
    logic             n_blocked;
    logic             n_active;
    logic [CNT_W-1:0] n_total;
    logic [CNT_W-1:0] n_low;
    logic [CNT_W-1:0] total_inc;
    logic [CNT_W-1:0] low_inc;
    logic [CNT_W-1:0] high_count;

    assign total_inc  = r_total + CNT_W'(1);
    assign low_inc    = r_low + CNT_W'(!i_ctrl.level);
    assign high_count = total_inc - low_inc;

    always_comb begin
        n_blocked = r_blocked;
        n_active  = r_active;
        n_total   = r_total;
        n_low     = r_low;
        if (i_ctrl.press) begin
            n_blocked = 1'b1;
            n_active  = 1'b1;
        end else if (i_ctrl.sample && r_active) begin
            n_total = total_inc;
            n_low   = low_inc;
            if (CMP_W'(total_inc) == CMP_W'(i_limit)) begin
                n_blocked = 1'b0;
            end
            // Enough samples with the button up: the release is settled.
            if (CMP_W'(high_count) > CMP_W'(i_limit)) begin
                n_active  = 1'b0;
                n_blocked = 1'b0;
                n_total   = '0;
                n_low     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked <= 1'b0;
            r_active  <= 1'b0;
            r_total   <= '0;
            r_low     <= '0;
        end else begin
            r_blocked <= n_blocked;
            r_active  <= n_active;
            r_total   <= n_total;
            r_low     <= n_low;
        end
    end

    assign o_status.blocked = r_blocked;
    assign o_status.active  = r_active;

endmodule

[hw/rtl/bcd_stopwatch_with_debounce.sv]
// Top level of the one-button BCD stopwatch with press debounce.
//
// Usage: each input transaction on the slave stream carries one event in
// i_s_tuser (press, millisecond tick, second tick or button sample) and the
// sampled button level in i_s_tdata. For every accepted transaction exactly
// one result transaction leaves on the master stream, showing the six digits,
// the mode and the two debounce flags as they stand after that event.
// The result is valid in the cycle after acceptance. Throughput is one
// event per cycle; the digit chain ripples its carry through two chains of
// three cells and the debounce counters add, subtract and compare, all
// combinational. The state registers themselves hold the result, so while
// the receiver stalls o_s_tready is low and the state (and thus the result)
// is frozen; a new event is taken in the same cycle that the pending result
// is taken. The debounce limit is written through the APB port at byte
// address 0; the user must write it only while the block is idle, which
// the block does not enforce. Synchronous reset clears the digits, mode,
// flags and counters, empties the output and sets the limit to 500.
module bcd_stopwatch_with_debounce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: tdata bit 0 button_level; tuser bits 1:0 command.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] button_level, [7:1] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    // Master stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] ms_ones, [7:4] ms_tens, [11:8] ms_hundreds, [15:12] sec_ones,
    // [18:16] sec_tens, [22:19] minutes, [24:23] mode, [25] press_blocked,
    // [26] debouncing, [31:27] zero
    output logic [31:0] o_m_tdata,
    // APB configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcdsw_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    t_mode              r_mode;
    t_mode              n_mode;
    logic               r_valid;
    logic               n_valid;

    logic               s_accept;
    t_cmd               cmd;
    logic               running;
    logic               press_ok;
    logic               press_clear;
    logic               ms_full;
    logic               ms_en;
    logic               sec_en;

    logic [DIGIT_W-1:0] digit [NUM_DIGITS];
    logic               carry [NUM_DIGITS];
    logic               cell_inc [NUM_DIGITS];
    logic               cell_clr [NUM_DIGITS];

    t_deb_ctrl          deb_ctrl;
    t_deb_status        deb_status;

    // ---------------------------------------------------------------
    // Configuration register.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEBOUNCE_LIMIT) ? 32'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DEBOUNCE_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the state registers double as the output register, so a
    // new event may enter only when the last result has gone or is going.
    // ---------------------------------------------------------------
    assign o_s_tready = !r_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign cmd        = t_cmd'(i_s_tuser);

    assign n_valid = s_accept ? 1'b1 : (i_m_tready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // ---------------------------------------------------------------
    // Event decode.
    // ---------------------------------------------------------------
    assign running     = (r_mode == MODE_RUN);
    assign press_ok    = s_accept && cmd == CMD_PRESS && !deb_status.blocked;
    assign press_clear = press_ok && r_mode == MODE_STOP;
    // The milliseconds hold at 999 until the next second tick.
    assign ms_full     = digit[D_MS_ONES] == DIGIT_W'(9)
                      && digit[D_MS_TENS] == DIGIT_W'(9)
                      && digit[D_MS_HUNDS] == DIGIT_W'(9);
    assign ms_en       = s_accept && cmd == CMD_MS_TICK && running && !ms_full;
    assign sec_en      = s_accept && cmd == CMD_SEC_TICK && running;

    // ---------------------------------------------------------------
    // Mode state machine: zeroed -> running -> stopped -> zeroed.
    // ---------------------------------------------------------------
    always_comb begin
        n_mode = r_mode;
        if (press_ok) begin
            unique case (r_mode)
                MODE_ZERO: n_mode = MODE_RUN;
                MODE_RUN:  n_mode = MODE_STOP;
                MODE_STOP: n_mode = MODE_ZERO;
                default:   n_mode = MODE_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ZERO;
        end else begin
            r_mode <= n_mode;
        end
    end

    // ---------------------------------------------------------------
    // Digit chain. The millisecond cells are fed by the millisecond tick
    // and cleared by the second tick; the seconds cells start a fresh
    // carry from the second tick. A press out of the stopped mode clears
    // every cell.
    // ---------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            cell_clr[k] = press_clear;
            cell_inc[k] = 1'b0;
        end
        for (int k = D_MS_ONES; k <= D_MS_HUNDS; k++) begin
            cell_clr[k] = press_clear || sec_en;
        end
        cell_inc[D_MS_ONES]  = ms_en;
        cell_inc[D_MS_TENS]  = carry[D_MS_ONES];
        cell_inc[D_MS_HUNDS] = carry[D_MS_TENS];
        cell_inc[D_SEC_ONES] = sec_en;
        cell_inc[D_SEC_TENS] = carry[D_SEC_ONES];
        cell_inc[D_MINUTES]  = carry[D_SEC_TENS];
    end

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        bcdsw_digit_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (cell_clr[g]),
            .i_inc     (cell_inc[g]),
            .i_modulus (digit_modulus(g)),
            .o_digit   (digit[g]),
            .o_carry   (carry[g])
        );
    end

    // ---------------------------------------------------------------
    // Debounce unit.
    // ---------------------------------------------------------------
    assign deb_ctrl.press  = press_ok;
    assign deb_ctrl.sample = s_accept && cmd == CMD_SAMPLE;
    assign deb_ctrl.level  = i_s_tdata[0];

    bcdsw_debounce u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (deb_ctrl),
        .i_limit  (r_limit),
        .o_status (deb_status)
    );

    // ---------------------------------------------------------------
    // Result.
    // ---------------------------------------------------------------
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {5'b0,
                         deb_status.active,
                         deb_status.blocked,
                         r_mode,
                         digit[D_MINUTES],
                         digit[D_SEC_TENS][2:0],
                         digit[D_SEC_ONES],
                         digit[D_MS_HUNDS],
                         digit[D_MS_TENS],
                         digit[D_MS_ONES]};

endmodule

[hw/rtl/bcdsw_checker.sv]
// Port-level checker for the stopwatch, bound to the top level.
`include "bcd_stopwatch_with_debounce_macros.svh"

module bcdsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    logic stalled;
    logic block_ok;
    logic digits_ok;

    assign stalled   = o_m_tvalid && !i_m_tready;
    assign block_ok  = !o_m_tdata[25] || o_m_tdata[26];
    assign digits_ok = o_m_tdata[3:0] <= 4'd9 && o_m_tdata[7:4] <= 4'd9
                    && o_m_tdata[11:8] <= 4'd9 && o_m_tdata[15:12] <= 4'd9
                    && o_m_tdata[18:16] <= 3'd5 && o_m_tdata[22:19] <= 4'd9;

    // A stalled result must not move.
    `BCDSW_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, stalled, $stable(o_m_tdata))

    // With no result pending the block always takes input.
    `BCDSW_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // Presses are only blocked while debounce is running.
    `BCDSW_ASSERT_NOW(a_block_needs_debounce, i_clk, i_rst_n, o_m_tvalid, block_ok)

    // Every digit stays within its BCD range.
    `BCDSW_ASSERT_NOW(a_digit_range, i_clk, i_rst_n, o_m_tvalid, digits_ok)

endmodule

bind bcd_stopwatch_with_debounce bcdsw_checker u_bcdsw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[tb/tb_bcd_stopwatch_with_debounce.sv]
// Self-checking testbench for the one-button BCD stopwatch with press debounce.
`timescale 1ns / 1ps

module tb_bcd_stopwatch_with_debounce;

    import bcdsw_pkg::*;

    // Generous bound on the whole run. The slowest correct run is roughly
    // 1100 events, each with the longest sender gap and the longest receiver
    // stall.
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTS  = 30;

    // Byte address of the debounce limit register.
    localparam logic [2:0] LIMIT_ADDR = {REG_DEBOUNCE_LIMIT, 2'b00};

    // What the block shows after one event.
    typedef struct {
        logic [3:0] ms_ones;
        logic [3:0] ms_tens;
        logic [3:0] ms_hunds;
        logic [3:0] sec_ones;
        logic [2:0] sec_tens;
        logic [3:0] minutes;
        logic [1:0] mode;
        logic       blocked;
        logic       debouncing;
    } t_watch_view;

    // The tracker keeps its own copy of the stopwatch and the debounce
    // counters, works out the display after every accepted event and
    // compares it with what the block sends back.
    class stopwatch_tracker;
        t_mode              mode;
        logic [3:0]         digit [NUM_DIGITS];
        logic               blocked;
        logic               active;
        logic [CNT_W-1:0]   total;
        logic [CNT_W-1:0]   low;
        logic [LIMIT_W-1:0] limit;
        t_watch_view        pending[$];
        int                 errors;
        int                 checked;
        int                 ms_holds;
        int                 minute_wraps;
        int                 releases;
        int                 blocked_presses;

        function new();
            mode    = MODE_ZERO;
            foreach (digit[i]) digit[i] = 4'd0;
            blocked = 1'b0;
            active  = 1'b0;
            total   = '0;
            low     = '0;
            limit   = LIMIT_RESET;
            errors  = 0;
            checked = 0;
            ms_holds        = 0;
            minute_wraps    = 0;
            releases        = 0;
            blocked_presses = 0;
        endfunction

        function void report(string what, int got, int want);
            if (errors < MAX_PRINTS) begin
                $display("mismatch: %s got %0d expected %0d", what, got, want);
            end
            errors++;
        endfunction

        function void apply_press();
            if (blocked) begin
                blocked_presses++;
                return;
            end
            case (mode)
                MODE_ZERO: begin
                    mode = MODE_RUN;
                end
                MODE_RUN: begin
                    mode = MODE_STOP;
                end
                default: begin
                    foreach (digit[i]) digit[i] = 4'd0;
                    mode = MODE_ZERO;
                end
            endcase
            // A press during debounce leaves the counters as they are.
            blocked = 1'b1;
            active  = 1'b1;
        endfunction

        function void apply_ms_tick();
            if (mode != MODE_RUN) return;
            if (digit[D_MS_ONES] == 4'd9 && digit[D_MS_TENS] == 4'd9 &&
                digit[D_MS_HUNDS] == 4'd9) begin
                // 999 holds until the next second tick.
                ms_holds++;
                return;
            end
            if (digit[D_MS_ONES] != 4'd9) begin
                digit[D_MS_ONES] = digit[D_MS_ONES] + 4'd1;
            end else begin
                digit[D_MS_ONES] = 4'd0;
                if (digit[D_MS_TENS] != 4'd9) begin
                    digit[D_MS_TENS] = digit[D_MS_TENS] + 4'd1;
                end else begin
                    digit[D_MS_TENS]  = 4'd0;
                    digit[D_MS_HUNDS] = (digit[D_MS_HUNDS] == 4'd9) ? 4'd0
                                                                    : digit[D_MS_HUNDS] + 4'd1;
                end
            end
        endfunction

        function void apply_sec_tick();
            if (mode != MODE_RUN) return;
            digit[D_MS_ONES]  = 4'd0;
            digit[D_MS_TENS]  = 4'd0;
            digit[D_MS_HUNDS] = 4'd0;
            if (digit[D_SEC_ONES] != 4'd9) begin
                digit[D_SEC_ONES] = digit[D_SEC_ONES] + 4'd1;
            end else begin
                digit[D_SEC_ONES] = 4'd0;
                if (digit[D_SEC_TENS] != 4'd5) begin
                    digit[D_SEC_TENS] = digit[D_SEC_TENS] + 4'd1;
                end else begin
                    digit[D_SEC_TENS] = 4'd0;
                    if (digit[D_MINUTES] != 4'd9) begin
                        digit[D_MINUTES] = digit[D_MINUTES] + 4'd1;
                    end else begin
                        digit[D_MINUTES] = 4'd0;
                        minute_wraps++;
                    end
                end
            end
        endfunction

        function void apply_sample(logic level);
            logic [CNT_W-1:0] high_count;
            if (!active) return;
            if (!level) low = low + 1'b1;
            total = total + 1'b1;
            if (total == limit) blocked = 1'b0;
            high_count = total - low;
            if (high_count > limit) begin
                active   = 1'b0;
                total    = '0;
                low      = '0;
                blocked  = 1'b0;
                releases++;
            end
        endfunction

        function void note_event(t_cmd cmd, logic level);
            t_watch_view view;
            case (cmd)
                CMD_PRESS:    apply_press();
                CMD_MS_TICK:  apply_ms_tick();
                CMD_SEC_TICK: apply_sec_tick();
                default:      apply_sample(level);
            endcase
            view.ms_ones    = digit[D_MS_ONES];
            view.ms_tens    = digit[D_MS_TENS];
            view.ms_hunds   = digit[D_MS_HUNDS];
            view.sec_ones   = digit[D_SEC_ONES];
            view.sec_tens   = digit[D_SEC_TENS][2:0];
            view.minutes    = digit[D_MINUTES];
            view.mode       = mode;
            view.blocked    = blocked;
            view.debouncing = active;
            pending.push_back(view);
        endfunction

        function void check_result(logic [31:0] word);
            t_watch_view want;
            if (pending.size() == 0) begin
                report("result with no event waiting, word", int'(word), 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (word[3:0] !== want.ms_ones) report("ms_ones", word[3:0], want.ms_ones);
            if (word[7:4] !== want.ms_tens) report("ms_tens", word[7:4], want.ms_tens);
            if (word[11:8] !== want.ms_hunds)
                report("ms_hundreds", word[11:8], want.ms_hunds);
            if (word[15:12] !== want.sec_ones)
                report("sec_ones", word[15:12], want.sec_ones);
            if (word[18:16] !== want.sec_tens)
                report("sec_tens", word[18:16], want.sec_tens);
            if (word[22:19] !== want.minutes) report("minutes", word[22:19], want.minutes);
            if (word[24:23] !== want.mode) report("mode", word[24:23], want.mode);
            if (word[25] !== want.blocked) report("press_blocked", word[25], want.blocked);
            if (word[26] !== want.debouncing)
                report("debouncing", word[26], want.debouncing);
        endfunction
    endclass

    // Every input has a known value from time zero.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic [1:0]  i_s_tuser  = CMD_PRESS;
    logic        i_m_tready = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = 3'd0;
    logic [31:0] pwdata     = 32'd0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic [31:0] prdata;
    logic        pready;

    stopwatch_tracker sb = new();

    // Random idling on both streams is enabled for most of the run and
    // switched off for the closing part.
    logic idle_on    = 1'b1;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   sent       = 0;

    bcd_stopwatch_with_debounce dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a run that hangs on a handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[bcd_stopwatch_with_debounce] ERROR");
            $finish;
        end
    end

    // Receiver: stalls come in bursts. A burst starts with the cycle that draws
    // it and then goes on while stall_left counts down to zero.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Output monitor: every result transaction is checked against the
    // oldest prediction. Signals are read at the edge, before any update
    // of that edge takes effect, so the order of processes does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
    end

    // Offers one event on the slave stream and returns at the edge at which
    // the transaction is taken. tvalid stays high for a following event
    // unless a gap is drawn, so it is never lowered and raised in one step.
    task automatic send_event(input t_cmd cmd, input logic level);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {7'd0, level};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_event(cmd, level);
        sent++;
    endtask

    // Stops the sender and waits until every predicted result has arrived.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // APB read of the limit register, checked in the access cycle.
    task automatic read_limit_check(input logic [LIMIT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[LIMIT_W-1:0] !== want) begin
            sb.report("debounce_limit read back", prdata[LIMIT_W-1:0], want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write of the limit register, followed by a read back. Only called
    // while the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        read_limit_check(value);
    endtask

    // Random events with the given percentages for press, millisecond tick
    // and second tick; the rest are samples. low_pct sets how often the
    // sampled button reads low. The level bit is random for other events.
    task automatic random_events(input int count, input int w_press, input int w_ms,
                                 input int w_sec, input int low_pct);
        int   pick;
        t_cmd cmd;
        logic level;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < w_press) begin
                cmd = CMD_PRESS;
            end else if (pick < w_press + w_ms) begin
                cmd = CMD_MS_TICK;
            end else if (pick < w_press + w_ms + w_sec) begin
                cmd = CMD_SEC_TICK;
            end else begin
                cmd = CMD_SAMPLE;
            end
            level = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
            send_event(cmd, level);
        end
    endtask

    // Presses and releases the button until the watch runs with presses
    // free again. Relies on a small limit so that release comes quickly.
    task automatic bring_to_running();
        while (!(sb.mode == MODE_RUN && !sb.blocked)) begin
            if (sb.blocked) begin
                send_event(CMD_SAMPLE, 1'b1);
            end else begin
                send_event(CMD_PRESS, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The limit comes out of reset at 500.
        read_limit_check(LIMIT_RESET);

        // Directed part under the reset limit: ticks and samples while the
        // watch is zeroed are ignored, a press starts it, a second press
        // during debounce is blocked, and a few samples count without
        // reaching the limit.
        send_event(CMD_MS_TICK, 1'b1);
        send_event(CMD_SEC_TICK, 1'b0);
        send_event(CMD_SAMPLE, 1'b0);
        send_event(CMD_SAMPLE, 1'b1);
        send_event(CMD_PRESS, 1'b0);
        send_event(CMD_PRESS, 1'b1);
        send_event(CMD_MS_TICK, 1'b0);
        send_event(CMD_MS_TICK, 1'b1);
        send_event(CMD_MS_TICK, 1'b0);
        send_event(CMD_SEC_TICK, 1'b1);
        send_event(CMD_SAMPLE, 1'b0);
        send_event(CMD_SAMPLE, 1'b0);
        send_event(CMD_SAMPLE, 1'b1);
        wait_for_results();

        // Smallest limit: one more high sample ends debounce, then a press
        // stops the watch, a low sample lifts the block at the limit, and a
        // press during the still active debounce zeroes the digits without
        // clearing the counters. Two high samples then release the button.
        write_limit(16'd1);
        send_event(CMD_SAMPLE, 1'b1);
        send_event(CMD_PRESS, 1'b0);
        send_event(CMD_MS_TICK, 1'b1);
        send_event(CMD_SAMPLE, 1'b0);
        send_event(CMD_PRESS, 1'b1);
        send_event(CMD_SAMPLE, 1'b1);
        send_event(CMD_SAMPLE, 1'b1);
        send_event(CMD_PRESS, 1'b0);
        send_event(CMD_SAMPLE, 1'b1);
        send_event(CMD_SAMPLE, 1'b1);
        wait_for_results();

        // General random mix over a few small limits. Each group ends with
        // the sender held back until every result is in.
        for (int g = 0; g < 3; g++) begin
            write_limit(16'($urandom_range(1, 12)));
            random_events(60, 12, 30, 18, 30);
            wait_for_results();
        end

        // Second ticks until the seconds carry through the minutes and the
        // minutes digit wraps from nine back to zero.
        write_limit(16'd2);
        bring_to_running();
        random_events(660, 0, 4, 95, 50);
        wait_for_results();

        // Largest limit: once a press is taken, presses stay blocked and
        // debounce never ends.
        write_limit(16'hFFFF);
        random_events(100, 12, 30, 18, 30);
        wait_for_results();

        // Closing part with no idling on either side.
        idle_on <= 1'b0;
        write_limit(16'($urandom_range(1, 8)));
        random_events(100, 12, 30, 18, 30);
        wait_for_results();

        // Wait for any stray result before the summary.
        repeat (4) @(posedge i_clk);

        $display("ran %0d events, %0d results checked, limits from 1 to 65535",
                 sent, sb.checked);
        $display("seen: %0d ms holds, %0d minute wraps, %0d releases, %0d blocked presses",
                 sb.ms_holds, sb.minute_wraps, sb.releases, sb.blocked_presses);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[bcd_stopwatch_with_debounce] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("[bcd_stopwatch_with_debounce] ERROR");
        end
        $finish;
    end

endmodule

[bcd_stopwatch_with_debounce.f]
+incdir+hw/rtl
hw/rtl/bcdsw_pkg.sv
hw/rtl/bcdsw_digit_cell.sv
hw/rtl/bcdsw_debounce.sv
hw/rtl/bcd_stopwatch_with_debounce.sv
hw/rtl/bcdsw_checker.sv
tb/tb_bcd_stopwatch_with_debounce.sv
